### design/rep_pkg.sv
// Shared constants and types for the ray edge picker.
`timescale 1ns / 1ps
`default_nettype none
package rep_pkg;

	localparam int DEF_COORD_BITS = 12;
	localparam int DEF_MAX_HITS   = 5;

	localparam int GRAY_W     = 8;
	localparam int THRESH_W   = 8;
	localparam int MODE_W     = 2;
	localparam int PICK_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PICK_INDEX = 2'd2;

	localparam logic [MODE_W-1:0] EDGE_RISE = 2'd0;
	localparam logic [MODE_W-1:0] EDGE_FALL = 2'd1;
	localparam logic [MODE_W-1:0] EDGE_ABS  = 2'd2;

	localparam logic [MODE_W-1:0]   RST_EDGE_MODE  = EDGE_RISE;
	localparam logic [THRESH_W-1:0] RST_THRESHOLD  = 8'd20;
	localparam logic [PICK_W-1:0]   RST_PICK_INDEX = 3'd1;

	// Classification of one sample as it travels from front to back.
	typedef struct packed {
		logic hit;
		logic first;
		logic last;
	} rep_cls_t;

	localparam int CLS_W = $bits(rep_cls_t);

endpackage
`default_nettype wire

### design/rep_fifo.sv
// Small synchronous queue built from registers.
`timescale 1ns / 1ps
`default_nettype none
module rep_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### design/rep_front.sv
// Front stage: compare each sample with the previous one and flag hits.
`timescale 1ns / 1ps
`default_nettype none
module rep_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [rep_pkg::GRAY_W-1:0]     gray,
	input  wire logic                           inside_req,
	input  wire logic                           first,
	input  wire logic                           last,
	input  wire logic [rep_pkg::MODE_W-1:0]     edge_mode,
	input  wire logic [rep_pkg::THRESH_W-1:0]   threshold,
	output rep_pkg::rep_cls_t                   cls
);
	import rep_pkg::*;

	logic [GRAY_W-1:0] prev_gray_q;
	logic signed [GRAY_W+1:0] diff, thr, mag;
	logic mode_hit;

	always_comb begin
		diff = $signed({2'b00, gray}) - $signed({2'b00, prev_gray_q});
		thr  = $signed({2'b00, threshold});
		mag  = (diff < 0) ? -diff : diff;
		unique case (edge_mode)
			EDGE_RISE: mode_hit = (diff > thr);
			EDGE_FALL: mode_hit = (diff < -thr);
			EDGE_ABS:  mode_hit = (mag > thr);
			default:   mode_hit = 1'b0;
		endcase
		cls.hit   = mode_hit && inside_req && !first;
		cls.first = first;
		cls.last  = last;
	end

	// Every accepted sample becomes the reference, valid or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_gray_q <= '0;
		end else if (accept) begin
			prev_gray_q <= gray;
		end
	end

endmodule
`default_nettype wire

### design/rep_back.sv
// Back stage: count hits, hold the picked coordinates, emit per-ray results.
`timescale 1ns / 1ps
`default_nettype none
module rep_back #(
	parameter int COORD_BITS = rep_pkg::DEF_COORD_BITS,
	parameter int MAX_HITS   = rep_pkg::DEF_MAX_HITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         mid_empty,
	input  wire rep_pkg::rep_cls_t            mid_cls,
	input  wire logic [COORD_BITS-1:0]        mid_x,
	input  wire logic [COORD_BITS-1:0]        mid_y,
	output logic                              mid_pop,
	input  wire logic [rep_pkg::PICK_W-1:0]   pick_index,
	input  wire logic                         res_full,
	output logic                              res_push,
	output logic                              res_found,
	output logic [COORD_BITS-1:0]             res_x,
	output logic [COORD_BITS-1:0]             res_y
);
	import rep_pkg::*;

	localparam int CNT_W = $clog2(MAX_HITS + 1);
	localparam int CMP_W = ((CNT_W > PICK_W) ? CNT_W : PICK_W) + 1;

	logic [CNT_W-1:0]      hit_count_q, cnt_next;
	logic [COORD_BITS-1:0] picked_x_q, picked_y_q, px_next, py_next;
	logic [CMP_W-1:0]      cnt_inc, pick_eff;

	// Stall only a ray end whose result has nowhere to go.
	assign mid_pop = !mid_empty && (!mid_cls.last || !res_full);

	always_comb begin
		cnt_inc  = CMP_W'(hit_count_q) + 1'b1;
		pick_eff = (pick_index == '0) ? CMP_W'(1) : CMP_W'(pick_index);
		cnt_next = hit_count_q;
		px_next  = picked_x_q;
		py_next  = picked_y_q;
		if (mid_cls.first) begin
			cnt_next = '0;
			px_next  = '0;
			py_next  = '0;
		end else if (mid_cls.hit && (hit_count_q < CNT_W'(MAX_HITS))) begin
			cnt_next = CNT_W'(cnt_inc);
			if (cnt_inc <= pick_eff) begin
				px_next = mid_x;
				py_next = mid_y;
			end
		end
		res_push  = mid_pop && mid_cls.last;
		res_found = (cnt_next != '0);
		res_x     = res_found ? px_next : '0;
		res_y     = res_found ? py_next : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_count_q <= '0;
			picked_x_q  <= '0;
			picked_y_q  <= '0;
		end else if (mid_pop) begin
			hit_count_q <= mid_cls.last ? '0 : cnt_next;
			picked_x_q  <= px_next;
			picked_y_q  <= py_next;
		end
	end

endmodule
`default_nettype wire

### design/ray_edge_picker.sv
// Top level of the ray edge picker: config registers, front, queues and back.
`timescale 1ns / 1ps
`default_nettype none
// Caliper-style edge picker for one scan ray. Push one gray sample per item,
// in scan order, with its coordinates, an inside flag and first/last marks.
// Each sample after the first is compared with the one before it; edge_mode
// selects a rise above threshold, a fall below minus threshold, or an
// absolute step above it. Hits are counted up to MAX_HITS and the coordinates
// of hit number pick_index (or of the last hit, when fewer) are kept. An item
// marked last yields one result: found plus edge_x/edge_y (zero if nothing
// was found). Throughput is one item per clock with no bubbles while full
// is low; the path is a subtract and compare in the front and a counter
// update in the back. A result passes through the sample queue and then the
// result queue before it shows at the output.
// Full rises only when the four-entry queue between front and back fills,
// which happens when results are not popped and the back holds a ray end.
// Write configuration only while the block is idle.
module ray_edge_picker #(
	parameter int COORD_BITS = rep_pkg::DEF_COORD_BITS,
	parameter int MAX_HITS   = rep_pkg::DEF_MAX_HITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// sample queue
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [rep_pkg::GRAY_W-1:0]      gray,
	input  wire logic [COORD_BITS-1:0]           pos_x,
	input  wire logic [COORD_BITS-1:0]           pos_y,
	input  wire logic                            inside_req,
	input  wire logic                            first,
	input  wire logic                            last,
	// result queue
	output logic                                 empty,
	input  wire logic                            pop,
	output logic                                 found,
	output logic [COORD_BITS-1:0]                edge_x,
	output logic [COORD_BITS-1:0]                edge_y,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [rep_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [rep_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rep_pkg::*;

	localparam int MID_W = CLS_W + 2 * COORD_BITS;
	localparam int RES_W = 1 + 2 * COORD_BITS;

	logic [MODE_W-1:0]   edge_mode_q;
	logic [THRESH_W-1:0] threshold_q;
	logic [PICK_W-1:0]   pick_index_q;

	logic                  in_accept;
	rep_cls_t              front_cls, mid_cls;
	logic [MID_W-1:0]      mid_wdata, mid_rdata;
	logic                  mid_empty, mid_pop;
	logic [COORD_BITS-1:0] mid_x, mid_y;

	logic                  res_push, res_full, res_found;
	logic [COORD_BITS-1:0] res_x, res_y;
	logic [RES_W-1:0]      res_rdata;

	// Configuration registers; out-of-range indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_mode_q  <= RST_EDGE_MODE;
			threshold_q  <= RST_THRESHOLD;
			pick_index_q <= RST_PICK_INDEX;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_EDGE_MODE:  edge_mode_q  <= cfg_data[MODE_W-1:0];
				CFG_THRESHOLD:  threshold_q  <= cfg_data[THRESH_W-1:0];
				CFG_PICK_INDEX: pick_index_q <= cfg_data[PICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_accept = push && !full;

	// Front: classify the sample against the previous gray value.
	rep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.gray       (gray),
		.inside_req (inside_req),
		.first      (first),
		.last       (last),
		.edge_mode  (edge_mode_q),
		.threshold  (threshold_q),
		.cls        (front_cls)
	);

	// Decoupling queue between classification and hit bookkeeping.
	assign mid_wdata = {front_cls, pos_x, pos_y};

	rep_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept),
		.wr_data (mid_wdata),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.full    (full),
		.empty   (mid_empty)
	);

	assign mid_cls = rep_cls_t'(mid_rdata[MID_W-1 -: CLS_W]);
	assign mid_x   = mid_rdata[2*COORD_BITS-1 -: COORD_BITS];
	assign mid_y   = mid_rdata[COORD_BITS-1:0];

	// Back: count hits, keep the picked coordinates, build the result item.
	rep_back #(
		.COORD_BITS (COORD_BITS),
		.MAX_HITS   (MAX_HITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_empty  (mid_empty),
		.mid_cls    (mid_cls),
		.mid_x      (mid_x),
		.mid_y      (mid_y),
		.mid_pop    (mid_pop),
		.pick_index (pick_index_q),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_found  (res_found),
		.res_x      (res_x),
		.res_y      (res_y)
	);

	// Result queue: holds finished items until the consumer pops them.
	rep_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data ({res_found, res_x, res_y}),
		.rd_en   (pop),
		.rd_data (res_rdata),
		.full    (res_full),
		.empty   (empty)
	);

	assign found  = res_rdata[RES_W-1];
	assign edge_x = res_rdata[2*COORD_BITS-1 -: COORD_BITS];
	assign edge_y = res_rdata[COORD_BITS-1:0];

endmodule
`default_nettype wire

### design/rep_checker.sv
// Port-level checks for the ray edge picker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rep_checker #(
	parameter int COORD_BITS = rep_pkg::DEF_COORD_BITS
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  push,
	input wire logic                  full,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire logic                  found,
	input wire logic [COORD_BITS-1:0] edge_x,
	input wire logic [COORD_BITS-1:0] edge_y
);

	// A miss reports zero coordinates.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !found) |-> (edge_x == '0 && edge_y == '0))
		else $error("miss result carries nonzero coordinates");

	// The sample queue only fills by taking an item.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted item");

	// A waiting result holds until popped.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(found) && $stable(edge_x)
			&& $stable(edge_y)))
		else $error("result changed while waiting");

endmodule

bind ray_edge_picker rep_checker #(.COORD_BITS(COORD_BITS)) u_rep_checker (.*);
`default_nettype wire
